FILE: rtl/core/sstm_pkg.sv
// ----------------------------------------------------------------------------
// sstm_pkg: shared definitions of the sensor stream timing monitor
// Field widths and bit positions of the stream items, register reset values,
// register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package sstm_pkg;

  // Input item layout (tdata); the item kind travels in tuser.
  localparam int STAMP_W       = 64;
  localparam int ARRIVAL_W     = 63;
  localparam int AXIS_W        = 32;
  localparam int S_STAMP_LSB   = 0;
  localparam int S_ARRIVAL_LSB = S_STAMP_LSB + STAMP_W;
  localparam int S_AX_LSB      = S_ARRIVAL_LSB + ARRIVAL_W;
  localparam int S_AY_LSB      = S_AX_LSB + AXIS_W;
  localparam int S_AZ_LSB      = S_AY_LSB + AXIS_W;
  localparam int S_DATA_W      = 224;

  // Result item layout (tdata)
  localparam int CNT_FIELD_W   = 32;
  localparam int TOTAL_W       = 48;
  localparam int M_WCNT_LSB    = 0;
  localparam int M_TCNT_LSB    = M_WCNT_LSB + CNT_FIELD_W;
  localparam int M_LAST_LSB    = M_TCNT_LSB + TOTAL_W;
  localparam int M_MAXS_LSB    = M_LAST_LSB + STAMP_W;
  localparam int M_SGAP_LSB    = M_MAXS_LSB + ARRIVAL_W;
  localparam int M_BACK_LSB    = M_SGAP_LSB + CNT_FIELD_W;
  localparam int M_WORST_LSB   = M_BACK_LSB + CNT_FIELD_W;
  localparam int M_MAXA_LSB    = M_WORST_LSB + STAMP_W;
  localparam int M_AGAP_LSB    = M_MAXA_LSB + ARRIVAL_W;
  localparam int M_CLIP_LSB    = M_AGAP_LSB + CNT_FIELD_W;
  localparam int M_WARN_LSB    = M_CLIP_LSB + CNT_FIELD_W;
  localparam int M_ELAP_LSB    = M_WARN_LSB + 1;
  localparam int M_DATA_W      = 528;

  // Item kinds carried in tuser
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_REPORT = 1'b1
  } func_e;

  // Register file
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int LIMIT_W  = 32;
  localparam int CLIP_W   = 31;

  typedef enum logic [1:0] {
    REG_STAMP_GAP   = 2'd0,
    REG_ARRIVAL_GAP = 2'd1,
    REG_ACCEL_CLIP  = 2'd2
  } reg_idx_e;

  localparam logic [LIMIT_W-1:0] STAMP_GAP_RESET   = 32'd20000000;
  localparam logic [LIMIT_W-1:0] ARRIVAL_GAP_RESET = 32'd20000000;
  localparam logic [CLIP_W-1:0]  ACCEL_CLIP_RESET  = 31'd249037;
  localparam logic [LIMIT_W-1:0] MIN_GAP_LIMIT     = 32'd1000000;

  // Limits as the datapath uses them: gap limits already floored.
  typedef struct packed {
    logic [LIMIT_W-1:0] stamp_gap_lim;
    logic [LIMIT_W-1:0] arrival_gap_lim;
    logic [CLIP_W-1:0]  clip_lim;
  } cfg_t;

endpackage

FILE: rtl/core/sstm_regs.sv
// ----------------------------------------------------------------------------
// sstm_regs: configuration registers of the timing monitor
// APB-style write and read of the three limits; the gap limits are also kept
// in a floored copy so that the datapath sees a ready-to-use threshold.
// ----------------------------------------------------------------------------
module sstm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sstm_pkg::PADDR_W-1:0]  paddr,
  input  logic [sstm_pkg::PDATA_W-1:0]  pwdata,
  output logic [sstm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output sstm_pkg::cfg_t                cfg_o
);
  import sstm_pkg::*;

  logic [LIMIT_W-1:0] stamp_gap_q,  stamp_gap_d;
  logic [LIMIT_W-1:0] arr_gap_q,    arr_gap_d;
  logic [CLIP_W-1:0]  clip_q,       clip_d;
  logic [LIMIT_W-1:0] stamp_eff_q,  stamp_eff_d;
  logic [LIMIT_W-1:0] arr_eff_q,    arr_eff_d;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);

  // Write decode; a write to an unused index is dropped.
  always_comb begin
    stamp_gap_d = stamp_gap_q;
    arr_gap_d   = arr_gap_q;
    clip_d      = clip_q;
    if (wr_en) begin
      unique case (idx)
        REG_STAMP_GAP:   stamp_gap_d = pwdata;
        REG_ARRIVAL_GAP: arr_gap_d   = pwdata;
        REG_ACCEL_CLIP:  clip_d      = pwdata[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Floored copies of the gap limits.
  always_comb begin
    stamp_eff_d = (stamp_gap_d < MIN_GAP_LIMIT) ? MIN_GAP_LIMIT : stamp_gap_d;
    arr_eff_d   = (arr_gap_d < MIN_GAP_LIMIT) ? MIN_GAP_LIMIT : arr_gap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_gap_q <= STAMP_GAP_RESET;
      arr_gap_q   <= ARRIVAL_GAP_RESET;
      clip_q      <= ACCEL_CLIP_RESET;
      stamp_eff_q <= STAMP_GAP_RESET;
      arr_eff_q   <= ARRIVAL_GAP_RESET;
    end else begin
      stamp_gap_q <= stamp_gap_d;
      arr_gap_q   <= arr_gap_d;
      clip_q      <= clip_d;
      stamp_eff_q <= stamp_eff_d;
      arr_eff_q   <= arr_eff_d;
    end
  end

  // Read mux returns the raw register values.
  always_comb begin
    unique case (idx)
      REG_STAMP_GAP:   prdata = stamp_gap_q;
      REG_ARRIVAL_GAP: prdata = arr_gap_q;
      REG_ACCEL_CLIP:  prdata = PDATA_W'(clip_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.stamp_gap_lim   = stamp_eff_q;
  assign cfg_o.arrival_gap_lim = arr_eff_q;
  assign cfg_o.clip_lim        = clip_q;

endmodule

FILE: rtl/core/sensor_stream_timing_monitor.sv
// ----------------------------------------------------------------------------
// sensor_stream_timing_monitor: timing statistics of a timestamped sample stream
// Forms stamp and arrival deltas per sample, counts gaps, backward or repeated
// stamps and clipped samples, and returns the window statistics on a report item.
// ----------------------------------------------------------------------------
// Usage
//   The s_axis channel carries items: tuser[0] = 0 is a sample, 1 a report.
//   Samples update the window statistics and give no result; a report gives
//   one item on m_axis with the statistics and elapsed time, then clears the
//   window. Limits are set over the APB port while the stream is idle.
//   Throughput: one item per cycle while no report waits for the output
//   register. An accepted item is registered, then processed by a single
//   pass through the delta, compare and counter logic; the critical path is
//   the 64-bit stamp subtraction followed by the peak and limit compares.
//   A report's result is loaded into the output register when the report
//   leaves the input register, and m_axis takes it from there.
//   When the receiver stalls, the result stays in the output register;
//   samples keep flowing, and only a second report waits in the input
//   register until the output register is free.
//   Reset clears all statistics, the previous-sample state and the limits
//   to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sensor_stream_timing_monitor #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: header_stamp[63:0], arrival_ns[126:64], accel_x[158:127],
  //        accel_y[190:159], accel_z[222:191], zero pad [223]
  input  logic [sstm_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: func[0]
  input  logic [0:0]                     s_axis_tuser,
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: window_count[31:0], total_count[79:32], last_stamp_delta[143:80],
  //        max_stamp_delta[206:144], stamp_gap_count[238:207],
  //        backward_count[270:239], worst_gap_stamp[334:271],
  //        max_arrival_delta[397:335], arrival_gap_count[429:398],
  //        clip_count[461:430], warning[462], elapsed_ns[525:463], pad [527:526]
  output logic [sstm_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sstm_pkg::PADDR_W-1:0]   paddr,
  input  logic [sstm_pkg::PDATA_W-1:0]   pwdata,
  output logic [sstm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import sstm_pkg::*;

  localparam int CntW = (COUNTER_WIDTH > CNT_FIELD_W) ? CNT_FIELD_W : COUNTER_WIDTH;

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  cfg_t cfg;

  sstm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register
  logic                  s1_valid_q, s1_valid_d;
  func_e                 s1_func_q;
  logic [STAMP_W-1:0]    s1_stamp_q;
  logic [ARRIVAL_W-1:0]  s1_arr_q;
  logic [AXIS_W-1:0]     s1_ax_q, s1_ay_q, s1_az_q;
  logic                  in_acc, s1_go, out_free;

  // Monitor state
  logic                  prev_valid_q, prev_valid_d;
  logic [STAMP_W-1:0]    prev_stamp_q, prev_stamp_d;
  logic [ARRIVAL_W-1:0]  prev_arr_q, prev_arr_d;
  logic [ARRIVAL_W-1:0]  win_begin_q, win_begin_d;
  logic [TOTAL_W-1:0]    total_seen_q, total_seen_d;
  logic [CntW-1:0]       win_seen_q, win_seen_d;
  logic [CntW-1:0]       stamp_gaps_q, stamp_gaps_d;
  logic [CntW-1:0]       stamp_backs_q, stamp_backs_d;
  logic [CntW-1:0]       arr_gaps_q, arr_gaps_d;
  logic [CntW-1:0]       clips_q, clips_d;
  logic [STAMP_W-1:0]    recent_sd_q, recent_sd_d;
  logic [ARRIVAL_W-1:0]  peak_sd_q, peak_sd_d;
  logic [ARRIVAL_W-1:0]  peak_ad_q, peak_ad_d;
  logic [ARRIVAL_W-1:0]  worst_sd_q, worst_sd_d;
  logic [STAMP_W-1:0]    worst_time_q, worst_time_d;

  // Output register
  logic                  m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0]   m_data_q, m_data_d;

  // Datapath intermediates
  logic [STAMP_W-1:0]    diff, sd, ad, el;
  logic                  ovf, sd_pos, ad_pos, el_pos, clip_hit;
  logic [AXIS_W-1:0]     mag_x, mag_y, mag_z;

  // Handshake: samples always drain; a report needs a free output register.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && ((s1_func_q == FUNC_SAMPLE) || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= func_e'(s_axis_tuser[0]);
      s1_stamp_q <= s_axis_tdata[S_STAMP_LSB +: STAMP_W];
      s1_arr_q   <= s_axis_tdata[S_ARRIVAL_LSB +: ARRIVAL_W];
      s1_ax_q    <= s_axis_tdata[S_AX_LSB +: AXIS_W];
      s1_ay_q    <= s_axis_tdata[S_AY_LSB +: AXIS_W];
      s1_az_q    <= s_axis_tdata[S_AZ_LSB +: AXIS_W];
    end
  end

  // Deltas: the stamp difference saturates on signed overflow.
  always_comb begin
    diff   = s1_stamp_q - prev_stamp_q;
    ovf    = (s1_stamp_q[STAMP_W-1] ^ prev_stamp_q[STAMP_W-1]) &&
             (diff[STAMP_W-1] ^ s1_stamp_q[STAMP_W-1]);
    if (ovf) begin
      sd = s1_stamp_q[STAMP_W-1] ? {1'b1, {(STAMP_W-1){1'b0}}}
                                 : {1'b0, {(STAMP_W-1){1'b1}}};
    end else begin
      sd = diff;
    end
    sd_pos = !sd[STAMP_W-1] && (sd != '0);
    ad     = {1'b0, s1_arr_q} - {1'b0, prev_arr_q};
    ad_pos = !ad[STAMP_W-1] && (ad != '0);
    el     = {1'b0, s1_arr_q} - {1'b0, win_begin_q};
    el_pos = !el[STAMP_W-1] && (el != '0);
  end

  // Clip test: the most negative axis has magnitude 2^31 and always clips.
  always_comb begin
    mag_x    = s1_ax_q[AXIS_W-1] ? (~s1_ax_q + 1'b1) : s1_ax_q;
    mag_y    = s1_ay_q[AXIS_W-1] ? (~s1_ay_q + 1'b1) : s1_ay_q;
    mag_z    = s1_az_q[AXIS_W-1] ? (~s1_az_q + 1'b1) : s1_az_q;
    clip_hit = (mag_x >= {1'b0, cfg.clip_lim}) || (mag_y >= {1'b0, cfg.clip_lim}) ||
               (mag_z >= {1'b0, cfg.clip_lim});
  end

  // State update for samples and reports.
  always_comb begin
    prev_valid_d  = prev_valid_q;
    prev_stamp_d  = prev_stamp_q;
    prev_arr_d    = prev_arr_q;
    win_begin_d   = win_begin_q;
    total_seen_d  = total_seen_q;
    win_seen_d    = win_seen_q;
    stamp_gaps_d  = stamp_gaps_q;
    stamp_backs_d = stamp_backs_q;
    arr_gaps_d    = arr_gaps_q;
    clips_d       = clips_q;
    recent_sd_d   = recent_sd_q;
    peak_sd_d     = peak_sd_q;
    peak_ad_d     = peak_ad_q;
    worst_sd_d    = worst_sd_q;
    worst_time_d  = worst_time_q;
    if (s1_go) begin
      unique case (s1_func_q)
        FUNC_SAMPLE: begin
          win_seen_d   = bump(win_seen_q);
          total_seen_d = (total_seen_q == '1) ? total_seen_q : total_seen_q + 1'b1;
          if (prev_valid_q) begin
            recent_sd_d = sd;
            if (sd_pos && (sd[ARRIVAL_W-1:0] > peak_sd_q)) begin
              peak_sd_d = sd[ARRIVAL_W-1:0];
            end
            if (ad_pos && (ad[ARRIVAL_W-1:0] > peak_ad_q)) begin
              peak_ad_d = ad[ARRIVAL_W-1:0];
            end
            if (!sd_pos) begin
              stamp_backs_d = bump(stamp_backs_q);
            end else if (sd[ARRIVAL_W-1:0] > ARRIVAL_W'(cfg.stamp_gap_lim)) begin
              stamp_gaps_d = bump(stamp_gaps_q);
              // A tie with the worst gap so far moves the mark to this one.
              if (sd[ARRIVAL_W-1:0] >= worst_sd_q) begin
                worst_sd_d   = sd[ARRIVAL_W-1:0];
                worst_time_d = s1_stamp_q;
              end
            end
            if (ad_pos && (ad[ARRIVAL_W-1:0] > ARRIVAL_W'(cfg.arrival_gap_lim))) begin
              arr_gaps_d = bump(arr_gaps_q);
            end
          end
          if (clip_hit) begin
            clips_d = bump(clips_q);
          end
          prev_stamp_d = s1_stamp_q;
          prev_arr_d   = s1_arr_q;
          prev_valid_d = 1'b1;
        end
        FUNC_REPORT: begin
          win_begin_d   = s1_arr_q;
          win_seen_d    = '0;
          stamp_gaps_d  = '0;
          stamp_backs_d = '0;
          arr_gaps_d    = '0;
          clips_d       = '0;
          peak_sd_d     = '0;
          peak_ad_d     = '0;
          worst_sd_d    = '0;
          worst_time_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q  <= 1'b0;
      prev_stamp_q  <= '0;
      prev_arr_q    <= '0;
      win_begin_q   <= '0;
      total_seen_q  <= '0;
      win_seen_q    <= '0;
      stamp_gaps_q  <= '0;
      stamp_backs_q <= '0;
      arr_gaps_q    <= '0;
      clips_q       <= '0;
      recent_sd_q   <= '0;
      peak_sd_q     <= '0;
      peak_ad_q     <= '0;
      worst_sd_q    <= '0;
      worst_time_q  <= '0;
    end else begin
      prev_valid_q  <= prev_valid_d;
      prev_stamp_q  <= prev_stamp_d;
      prev_arr_q    <= prev_arr_d;
      win_begin_q   <= win_begin_d;
      total_seen_q  <= total_seen_d;
      win_seen_q    <= win_seen_d;
      stamp_gaps_q  <= stamp_gaps_d;
      stamp_backs_q <= stamp_backs_d;
      arr_gaps_q    <= arr_gaps_d;
      clips_q       <= clips_d;
      recent_sd_q   <= recent_sd_d;
      peak_sd_q     <= peak_sd_d;
      peak_ad_q     <= peak_ad_d;
      worst_sd_q    <= worst_sd_d;
      worst_time_q  <= worst_time_d;
    end
  end

  // Result packing from the statistics as they stand before the report.
  always_comb begin
    m_data_d = '0;
    m_data_d[M_WCNT_LSB  +: CNT_FIELD_W] = CNT_FIELD_W'(win_seen_q);
    m_data_d[M_TCNT_LSB  +: TOTAL_W]     = total_seen_q;
    m_data_d[M_LAST_LSB  +: STAMP_W]     = recent_sd_q;
    m_data_d[M_MAXS_LSB  +: ARRIVAL_W]   = peak_sd_q;
    m_data_d[M_SGAP_LSB  +: CNT_FIELD_W] = CNT_FIELD_W'(stamp_gaps_q);
    m_data_d[M_BACK_LSB  +: CNT_FIELD_W] = CNT_FIELD_W'(stamp_backs_q);
    m_data_d[M_WORST_LSB +: STAMP_W]     = worst_time_q;
    m_data_d[M_MAXA_LSB  +: ARRIVAL_W]   = peak_ad_q;
    m_data_d[M_AGAP_LSB  +: CNT_FIELD_W] = CNT_FIELD_W'(arr_gaps_q);
    m_data_d[M_CLIP_LSB  +: CNT_FIELD_W] = CNT_FIELD_W'(clips_q);
    m_data_d[M_WARN_LSB]                 = (stamp_gaps_q != '0) || (stamp_backs_q != '0) ||
                                           (arr_gaps_q != '0);
    // Elapsed time never reads below one nanosecond.
    m_data_d[M_ELAP_LSB  +: ARRIVAL_W]   = el_pos ? el[ARRIVAL_W-1:0] : ARRIVAL_W'(1);
  end

  // Output register
  logic m_load;
  assign m_load    = s1_go && (s1_func_q == FUNC_REPORT);
  assign m_valid_d = m_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: rtl/core/sstm_checker.sv
// ----------------------------------------------------------------------------
// sstm_checker: port-level checks of the timing monitor
// Watches the stream ports and checks result holding, report latency and the
// consistency of the reported statistics.
// ----------------------------------------------------------------------------
module sstm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [0:0]                    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sstm_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import sstm_pkg::*;

  logic [CNT_FIELD_W-1:0] wcnt, sgap, back, agap, clip;
  logic [TOTAL_W-1:0]     tcnt;
  logic                   warn;
  logic [ARRIVAL_W-1:0]   elap;

  assign wcnt = m_axis_tdata[M_WCNT_LSB +: CNT_FIELD_W];
  assign tcnt = m_axis_tdata[M_TCNT_LSB +: TOTAL_W];
  assign sgap = m_axis_tdata[M_SGAP_LSB +: CNT_FIELD_W];
  assign back = m_axis_tdata[M_BACK_LSB +: CNT_FIELD_W];
  assign agap = m_axis_tdata[M_AGAP_LSB +: CNT_FIELD_W];
  assign clip = m_axis_tdata[M_CLIP_LSB +: CNT_FIELD_W];
  assign warn = m_axis_tdata[M_WARN_LSB];
  assign elap = m_axis_tdata[M_ELAP_LSB +: ARRIVAL_W];

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A report taken while the output is empty passes the input register and then shows up as a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid
      |=> ##1 m_axis_tvalid)
    else $error("report result missing");

  // The warning flag matches the stamp gap, backward stamp and arrival gap counters.
  a_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> warn == ((sgap != '0) || (back != '0) || (agap != '0)))
    else $error("warning flag inconsistent");

  // Window counters never exceed the window sample count, nor that the total.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sgap <= wcnt) && (back <= wcnt) && (agap <= wcnt) &&
                      (clip <= wcnt) && (TOTAL_W'(wcnt) <= tcnt))
    else $error("window counters inconsistent");

  // Elapsed time is floored at one nanosecond.
  a_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> elap != '0)
    else $error("elapsed time is zero");

endmodule

bind sensor_stream_timing_monitor sstm_checker u_sstm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
